// ===== rtl/allocation_sample_decider_defines.svh =====
// assertion macros for the allocation sample decider
// used by the top level; no other dependencies
`ifndef ALLOCATION_SAMPLE_DECIDER_DEFINES_SVH
`define ALLOCATION_SAMPLE_DECIDER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// condition holds at every clock edge outside reset
`define ASD_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// antecedent implies consequent in the next cycle
`define ASD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASD_ASSERT_ALWAYS(lbl, cond, msg)
`define ASD_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== rtl/asd_pkg.sv =====
// shared types, constants and the generator step for the sample decider
// no dependencies
`default_nettype none

package asd_pkg;

    localparam int RATE_W  = 32;
    localparam int RNG_W   = 64;
    localparam int CNT_W   = $clog2(RNG_W);

    localparam int SHIFT_A = 13;
    localparam int SHIFT_B = 17;
    localparam int SHIFT_C = 5;

    localparam logic [RNG_W-1:0] DEFAULT_SEED = 64'd88172645463325252;

    // register select bit taken from paddr[3]
    localparam logic REG_RATE = 1'b0;
    localparam logic REG_SEED = 1'b1;

    typedef struct packed {
        logic                start;
        logic [RNG_W-1:0]    dividend;
        logic [RATE_W-1:0]   divisor;
    } rem_req_t;

    typedef struct packed {
        logic                busy;
        logic                done;
        logic [RATE_W-1:0]   rem;
    } rem_stat_t;

    function automatic logic [RNG_W-1:0] xorshift_step(input logic [RNG_W-1:0] w);
        logic [RNG_W-1:0] t;
        t = w ^ (w << SHIFT_A);
        t = t ^ (t >> SHIFT_B);
        t = t ^ (t << SHIFT_C);
        return t;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/allocation_sample_decider.sv =====
// allocation sample decider: disabled, sample-all and size-above-rate requests go
// from the accepting edge straight to hand-off (ST_DONE) and then m_tvalid; a generator
// request passes through generator step, 64 remainder bits, decision and output hand-off
// one request at a time: s_tready is high only in idle, a held result keeps the
// sequencer in hand-off, and the remainder unit works one bit per cycle
// reset: synchronous active-low aresetn clears control, rate 0, default seed, word 0
`default_nettype none
`include "allocation_sample_decider_defines.svh"

module allocation_sample_decider
    import asd_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,

    // request channel
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] alloc_size

    // result channel
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [0] take_sample, [7:1] zero

    // configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic [63:0]      prdata,
    output logic             pready
);

    // sequencer state codes
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_GEN  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [RATE_W-1:0] rate_reg, rate_next;
    logic [RNG_W-1:0]  seed_reg, seed_next;
    logic [RNG_W-1:0]  rng_reg, rng_next;
    logic [RATE_W-1:0] size_reg, size_next;
    logic              take_reg, take_next;
    logic              mvalid_reg, mvalid_next;
    logic              mdata_reg, mdata_next;

    logic              cfg_wr;
    logic              in_acc;
    logic [RNG_W-1:0]  gen_src;
    logic [RNG_W-1:0]  gen_val;
    rem_req_t          rem_req;
    rem_stat_t         rem_stat;

    // configuration: pready tied high, paddr[3] picks the register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[3] == REG_SEED) ? seed_reg : {32'd0, rate_reg};

    always_comb begin
        rate_next = rate_reg;
        seed_next = seed_reg;
        if (cfg_wr) begin
            if (paddr[3] == REG_RATE) begin
                rate_next = pwdata[RATE_W-1:0];
            end else begin
                seed_next = pwdata;
            end
        end
    end

    // generator word: zero reseeds from the register, a zero seed falls back
    // to the default seed
    assign gen_src = (rng_reg != '0) ? rng_reg :
                     (seed_reg != '0) ? seed_reg : DEFAULT_SEED;
    assign gen_val = xorshift_step(gen_src);

    assign s_tready = (state_reg == ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;

    // remainder unit gets the fresh generator value as dividend
    assign rem_req.start    = (state_reg == ST_GEN);
    assign rem_req.dividend = gen_val;
    assign rem_req.divisor  = rate_reg;

    asd_rem_unit u_rem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (rem_req),
        .stat    (rem_stat)
    );

    always_comb begin
        state_next  = state_reg;
        rng_next    = rng_reg;
        size_next   = size_reg;
        take_next   = take_reg;
        mvalid_next = mvalid_reg;
        mdata_next  = mdata_reg;

        // output register drains independently of the sequencer
        if (mvalid_reg && m_tready) begin
            mvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    size_next = s_tdata;
                    // disabled, sample-all and size above rate skip the generator
                    if (rate_reg == '0) begin
                        take_next  = 1'b0;
                        state_next = ST_DONE;
                    end else if (rate_reg == RATE_W'(1) || s_tdata > rate_reg) begin
                        take_next  = 1'b1;
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_GEN;
                    end
                end
            end
            ST_GEN: begin
                rng_next   = gen_val;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (rem_stat.done) begin
                    take_next  = (rem_stat.rem <= size_reg);
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                // hand off once the output slot is free or being emptied
                if (!mvalid_reg || m_tready) begin
                    mvalid_next = 1'b1;
                    mdata_next  = take_reg;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            rate_reg   <= '0;
            seed_reg   <= DEFAULT_SEED;
            rng_reg    <= '0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            rate_reg   <= rate_next;
            seed_reg   <= seed_next;
            rng_reg    <= rng_next;
            mvalid_reg <= mvalid_next;
        end
        size_reg  <= size_next;
        take_reg  <= take_next;
        mdata_reg <= mdata_next;
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = {7'd0, mdata_reg};

    // the remainder unit only runs while a request is in flight
    `ASD_ASSERT_ALWAYS(a_idle_unit_quiet, !(s_tready && rem_stat.busy), "unit busy in idle")
    // a generator step never leaves the word at zero
    `ASD_ASSERT_NEXT(a_gen_nonzero, state_reg == ST_GEN, rng_reg != '0, "generator word zero")
    // starting the unit makes it busy
    `ASD_ASSERT_NEXT(a_gen_starts, state_reg == ST_GEN, rem_stat.busy, "unit did not start")
    // a finished remainder moves the sequencer to hand-off
    `ASD_ASSERT_NEXT(a_div_to_done, state_reg == ST_DIV && rem_stat.done,
                     state_reg == ST_DONE, "missed remainder done")

endmodule

`default_nettype wire

// ===== rtl/asd_rem_unit.sv =====
// bit-serial restoring remainder: 64-bit dividend by 32-bit divisor
// depends on asd_pkg
`default_nettype none

module asd_rem_unit
    import asd_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire rem_req_t  req,
    output rem_stat_t      stat
);

    logic [RNG_W-1:0]  dvd_reg, dvd_next;
    logic [RATE_W-1:0] div_reg, div_next;
    logic [RATE_W-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [RATE_W:0]   trial;

    always_comb begin
        dvd_next  = dvd_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, dvd_reg[RNG_W-1]};
        if (req.start) begin
            dvd_next  = req.dividend;
            div_next  = req.divisor;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, div_reg}) begin
                rem_next = RATE_W'(trial - {1'b0, div_reg});
            end else begin
                rem_next = trial[RATE_W-1:0];
            end
            dvd_next = {dvd_reg[RNG_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(RNG_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        dvd_reg <= dvd_next;
        div_reg <= div_next;
        rem_reg <= rem_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign stat.rem  = rem_reg;

endmodule

`default_nettype wire
